FILE: design/gcmm_pkg.sv
// ---------------------------------------------------------------------------
// gcmm_pkg: shared types and constants for the gap cluster mode mean block
// Default sizes, fixed field widths and the back-end sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none
package gcmm_pkg;
  localparam int MaxValuesDef = 256;
  localparam int ValueBitsDef = 12;
  localparam int SampleW      = 12;
  localparam int GapW         = 12;
  localparam int MeanW        = 20;
  localparam int CountW       = 9;
  localparam logic [GapW-1:0] MinGapReset = 12'd10;

  typedef enum logic [3:0] {
    BK_IDLE, BK_KEY_RD, BK_KEY_CAP, BK_RANK, BK_PLACE,
    BK_SCAN, BK_CLOSE, BK_PREP, BK_DIVIDE, BK_FINISH, BK_SEND
  } back_state_t;
endpackage
`default_nettype wire

FILE: design/gcmm_front.sv
// ---------------------------------------------------------------------------
// gcmm_front: set loader
// Writes incoming values into the store, counts them and hands a job on.
// ---------------------------------------------------------------------------
`default_nettype none
module gcmm_front import gcmm_pkg::*; #(
  parameter int MAX_VALUES = MaxValuesDef,
  parameter int VALUE_BITS = ValueBitsDef,
  localparam int AW = $clog2(MAX_VALUES),
  localparam int CW = $clog2(MAX_VALUES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [15:0]           s_axis_tdata,
  input  wire logic                  s_axis_tlast,
  input  wire logic [AW-1:0]         st_raddr,
  output logic [VALUE_BITS-1:0]      st_rdata,
  input  wire logic                  st_free,
  output logic                       job_valid,
  input  wire logic                  job_ready,
  output logic [CW:0]                job_data
);
  logic [VALUE_BITS-1:0] store [MAX_VALUES];
  logic [CW-1:0]         count;
  logic                  ovf;
  logic                  hold;
  logic                  take;
  logic                  room;
  logic [VALUE_BITS-1:0] value;

  assign s_axis_tready = !hold && job_ready;
  assign take  = s_axis_tvalid && s_axis_tready;
  assign room  = count < CW'(MAX_VALUES);
  assign value = VALUE_BITS'(s_axis_tdata[SampleW-1:0]);

  assign job_valid = take && s_axis_tlast;
  assign job_data  = {(room ? count + 1'b1 : count), ovf | !room};

  always_ff @(posedge clk) begin
    if (take && room) begin
      store[count[AW-1:0]] <= value;
    end
    st_rdata <= store[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      hold  <= 1'b0;
    end else begin
      if (st_free) begin
        hold <= 1'b0;
      end
      if (take) begin
        if (s_axis_tlast) begin
          count <= '0;
          ovf   <= 1'b0;
          hold  <= 1'b1;
        end else if (room) begin
          count <= count + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/gcmm_queue.sv
// ---------------------------------------------------------------------------
// gcmm_queue: two-entry job queue
// Decouples the loader from the sort and scan sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
module gcmm_queue import gcmm_pkg::*; #(
  parameter int WIDTH = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);
  logic [WIDTH-1:0] slot [2];
  logic             wp;
  logic             rp;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign in_ready  = fill != 2'd2;
  assign out_valid = fill != 2'd0;
  assign out_data  = slot[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: design/gcmm_back.sv
// ---------------------------------------------------------------------------
// gcmm_back: sort, cluster scan and mean divide
// Rank sort into a second store, one scan pass, then a restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none
module gcmm_back import gcmm_pkg::*; #(
  parameter int MAX_VALUES = MaxValuesDef,
  parameter int VALUE_BITS = ValueBitsDef,
  localparam int AW = $clog2(MAX_VALUES),
  localparam int CW = $clog2(MAX_VALUES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  min_gap_we,
  input  wire logic [GapW-1:0]       min_gap_wdata,
  input  wire logic                  job_valid,
  output logic                       job_ready,
  input  wire logic [CW:0]           job_data,
  output logic [AW-1:0]              st_raddr,
  input  wire logic [VALUE_BITS-1:0] st_rdata,
  output logic                       st_free,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [39:0]                m_axis_tdata
);
  localparam int SW   = VALUE_BITS + CW;
  localparam int DW   = SW + 8;
  localparam int NW   = $clog2(DW + 1);
  localparam int GW   = (VALUE_BITS > GapW) ? VALUE_BITS : GapW;
  localparam int QW   = (DW > MeanW) ? DW : MeanW;
  localparam int KW   = (CW > CountW) ? CW : CountW;

  back_state_t state, state_next;

  logic [GapW-1:0]       min_gap;
  logic [CW-1:0]         n;
  logic                  ovf;
  logic [CW-1:0]         i;
  logic [CW-1:0]         j;
  logic [AW-1:0]         jd;
  logic                  dv;
  logic [VALUE_BITS-1:0] key;
  logic [AW-1:0]         rank;
  logic [VALUE_BITS-1:0] sorted [MAX_VALUES];
  logic [VALUE_BITS-1:0] b_rd;
  logic [AW-1:0]         b_addr;
  logic [VALUE_BITS-1:0] prev;
  logic [CW-1:0]         cur_len;
  logic [SW-1:0]         cur_sum;
  logic [CW-1:0]         best_len;
  logic [SW-1:0]         best_sum;
  logic [CW-1:0]         clusters;
  logic [NW-1:0]         steps;
  logic [CW-1:0]         rem;
  logic [DW-1:0]         dq;
  logic [MeanW-1:0]      mean;
  logic [CountW-1:0]     members;
  logic [CountW-1:0]     total;
  logic                  ovf_out;

  logic                  less;
  logic                  split;
  logic [CW:0]           rem_sh;
  logic                  ge;
  logic [QW-1:0]         q_ext;
  logic [KW-1:0]         len_ext;
  logic [KW-1:0]         clu_ext;

  assign less   = (st_rdata < key) || ((st_rdata == key) && (jd < i[AW-1:0]));
  assign split  = GW'(b_rd - prev) >= GW'(min_gap);
  assign rem_sh = {rem, dq[DW-1]};
  assign ge     = rem_sh >= {1'b0, best_len};
  assign q_ext  = QW'(dq);
  assign len_ext = KW'(best_len);
  assign clu_ext = KW'(clusters);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:    if (job_valid) state_next = BK_KEY_RD;
      BK_KEY_RD:  state_next = BK_KEY_CAP;
      BK_KEY_CAP: state_next = BK_RANK;
      BK_RANK:    if (!dv && j == n) state_next = BK_PLACE;
      BK_PLACE:   state_next = (i + 1'b1 == n) ? BK_SCAN : BK_KEY_RD;
      BK_SCAN:    if (!dv && j == n) state_next = BK_CLOSE;
      BK_CLOSE:   state_next = BK_PREP;
      BK_PREP:    state_next = BK_DIVIDE;
      BK_DIVIDE:  if (steps == NW'(1)) state_next = BK_FINISH;
      BK_FINISH:  state_next = BK_SEND;
      BK_SEND:    if (m_axis_tready) state_next = BK_IDLE;
      default:    state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready     = state == BK_IDLE;
    st_free       = (state == BK_PLACE) && (i + 1'b1 == n);
    m_axis_tvalid = state == BK_SEND;
    b_addr        = j[AW-1:0];
    case (state)
      BK_KEY_RD:  st_raddr = i[AW-1:0];
      BK_KEY_CAP: st_raddr = '0;
      default:    st_raddr = j[AW-1:0];
    endcase
  end

  assign m_axis_tdata = {1'b0, ovf_out, total, members, mean};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      min_gap <= MinGapReset;
    end else begin
      state <= state_next;
      if (min_gap_we) min_gap <= min_gap_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_PLACE) begin
      sorted[rank] <= key;
    end
    b_rd <= sorted[b_addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        n   <= job_data[CW:1];
        ovf <= job_data[0];
        i   <= '0;
      end
      BK_KEY_CAP: begin
        key  <= st_rdata;
        j    <= CW'(1);
        jd   <= '0;
        dv   <= 1'b1;
        rank <= '0;
      end
      BK_RANK: begin
        if (dv && less) rank <= rank + 1'b1;
        if (j < n) begin
          jd <= j[AW-1:0];
          dv <= 1'b1;
          j  <= j + 1'b1;
        end else begin
          dv <= 1'b0;
        end
      end
      BK_PLACE: begin
        i  <= i + 1'b1;
        j  <= '0;
        dv <= 1'b0;
      end
      BK_SCAN: begin
        if (dv) begin
          prev <= b_rd;
          if (jd == '0) begin
            cur_len  <= CW'(1);
            cur_sum  <= SW'(b_rd);
            clusters <= CW'(1);
            best_len <= '0;
            best_sum <= '0;
          end else if (split) begin
            if (cur_len > best_len) begin
              best_len <= cur_len;
              best_sum <= cur_sum;
            end
            clusters <= clusters + 1'b1;
            cur_len  <= CW'(1);
            cur_sum  <= SW'(b_rd);
          end else begin
            cur_len <= cur_len + 1'b1;
            cur_sum <= cur_sum + SW'(b_rd);
          end
        end
        if (j < n) begin
          jd <= j[AW-1:0];
          dv <= 1'b1;
          j  <= j + 1'b1;
        end else begin
          dv <= 1'b0;
        end
      end
      BK_CLOSE: begin
        if (cur_len > best_len) begin
          best_len <= cur_len;
          best_sum <= cur_sum;
        end
      end
      BK_PREP: begin
        dq    <= {best_sum, 8'd0} + DW'(best_len >> 1);
        rem   <= '0;
        steps <= NW'(DW);
      end
      BK_DIVIDE: begin
        rem   <= ge ? CW'(rem_sh - {1'b0, best_len}) : CW'(rem_sh);
        dq    <= {dq[DW-2:0], ge};
        steps <= steps - 1'b1;
      end
      BK_FINISH: begin
        mean    <= |(q_ext >> MeanW) ? '1 : q_ext[MeanW-1:0];
        members <= |(len_ext >> CountW) ? '1 : len_ext[CountW-1:0];
        total   <= |(clu_ext >> CountW) ? '1 : clu_ext[CountW-1:0];
        ovf_out <= ovf;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: design/gap_cluster_mode_mean.sv
// ---------------------------------------------------------------------------
// gap_cluster_mode_mean: mean of the most populated gap cluster
// Loads a set of values, sorts, splits on gaps, emits the largest cluster mean.
// ---------------------------------------------------------------------------
// Channel     Dir  Handshake                 Content
// s_axis      in   tvalid/tready             tdata: sample_value; tlast: last_sample
// m_axis      out  tvalid/tready             tdata: mean_q8, cluster_members,
//                                            cluster_total, overflow
// min_gap     in   min_gap_we (no back-pressure)  min_gap_wdata
//
// Loading accepts requests while the job queue has room. After the last request
// of a set the loader stalls until the back end has rank-sorted the store; the
// stall is set by the single read port of the store, and it is longer while the
// back end still finishes the previous set. Loading of the next set resumes
// then; scan and divide (one quotient bit per cycle) overlap with it.
// rst is synchronous and clears control state and min_gap (to 10).
// A result waiting on m_axis_tready holds in its output register.
// ---------------------------------------------------------------------------
`default_nettype none
module gap_cluster_mode_mean import gcmm_pkg::*; #(
  parameter int MAX_VALUES = MaxValuesDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,   // [11:0] sample_value
  input  wire logic              s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [39:0]            m_axis_tdata,   // [19:0] mean_q8, [28:20] cluster_members,
                                                 // [37:29] cluster_total, [38] overflow
  input  wire logic              min_gap_we,
  input  wire logic [GapW-1:0]   min_gap_wdata
);
  localparam int AW = $clog2(MAX_VALUES);
  localparam int CW = $clog2(MAX_VALUES + 1);

  // job descriptor: {value count, overflow flag}
  logic                  push_valid;
  logic                  push_ready;
  logic [CW:0]           push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [CW:0]           pop_data;
  // store read port, driven by the back end
  logic [AW-1:0]         st_raddr;
  logic [VALUE_BITS-1:0] st_rdata;
  logic                  st_free;

  gcmm_front #(.MAX_VALUES(MAX_VALUES), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .st_raddr, .st_rdata, .st_free,
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job_data  (push_data)
  );

  gcmm_queue #(.WIDTH(CW + 1)) u_queue (
    .clk, .rst,
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  gcmm_back #(.MAX_VALUES(MAX_VALUES), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst,
    .min_gap_we, .min_gap_wdata,
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job_data  (pop_data),
    .st_raddr, .st_rdata, .st_free,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for gap_cluster_mode_mean
// Streams sets of spacing values, predicts the largest gap cluster's mean and
// compares every result field; min_gap is changed between idle phases.
// ---------------------------------------------------------------------------
module tb_top;
  import gcmm_pkg::*;

  localparam int Depth     = MaxValuesDef;
  localparam int TimeLimit = 4000000;
  // back end: rank sort, scan, divide; generous settle margin
  localparam int SettleCycles = 80000;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic [MeanW-1:0]  mean_q8;
    logic [CountW-1:0] members;
    logic [CountW-1:0] clusters;
    logic              ovf;
  } cluster_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [11:0] sample_value
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [19:0] mean, [28:20] members, [37:29] total, [38] ovf
  logic min_gap_we = 1'b0;
  logic [GapW-1:0] min_gap_wdata = '0;

  gap_cluster_mode_mean dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .min_gap_we(min_gap_we), .min_gap_wdata(min_gap_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [SampleW-1:0] set_vals[$];
  logic               set_dropped;
  logic [GapW-1:0]    gap_now;

  sample_t      pending_reqs[$];
  cluster_res_t awaited_means[$];

  int send_idle_pct, recv_idle_pct;
  int errors, cycles, reqs_sent, sets_done, results_seen;
  bit hold_send;

  // one request into the predictor; a marked one closes the set
  function automatic void absorb_sample(sample_t s);
    logic [SampleW-1:0] srt[$];
    int n, run_start, run_len, best_start, best_len, groups;
    longint unsigned total, q;
    cluster_res_t r;
    if (set_vals.size() < Depth) set_vals = {set_vals, s.value};
    else set_dropped = 1'b1;
    if (!s.last) return;
    srt = set_vals;
    srt.sort();
    n = srt.size();
    groups = 1; run_start = 0; run_len = 1; best_start = 0; best_len = 0;
    for (int i = 1; i <= n; i++) begin
      if (i == n || (srt[i] - srt[i-1]) >= gap_now) begin
        // strict compare keeps the earliest cluster on a tie
        if (run_len > best_len) begin
          best_len = run_len;
          best_start = run_start;
        end
        if (i < n) begin
          groups++;
          run_start = i;
          run_len = 1;
        end
      end else begin
        run_len++;
      end
    end
    total = 0;
    for (int i = 0; i < best_len; i++) total += srt[best_start + i];
    q = (total * 256 + best_len / 2) / best_len;
    r.mean_q8  = (q > 64'hFFFFF) ? 20'hFFFFF : q[MeanW-1:0];
    r.members  = (best_len > 511) ? 9'h1FF : best_len[CountW-1:0];
    r.clusters = (groups > 511) ? 9'h1FF : groups[CountW-1:0];
    r.ovf      = set_dropped;
    awaited_means = {awaited_means, r};
    set_vals.delete();
    set_dropped = 1'b0;
  endfunction

  // driver: one request per handshake, random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          sample_t s;
          s = pending_reqs.pop_front();
          s_axis_tdata  <= {4'b0, s.value};
          s_axis_tlast  <= s.last;
          s_axis_tvalid <= 1'b1;
          absorb_sample(s);
          reqs_sent++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      cluster_res_t got, exp_r;
      got.mean_q8  = m_axis_tdata[19:0];
      got.members  = m_axis_tdata[28:20];
      got.clusters = m_axis_tdata[37:29];
      got.ovf      = m_axis_tdata[38];
      results_seen++;
      if (awaited_means.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = awaited_means.pop_front();
        if (got.mean_q8 !== exp_r.mean_q8) begin
          $error("mean_q8 exp %0d got %0d", exp_r.mean_q8, got.mean_q8); errors++;
        end
        if (got.members !== exp_r.members) begin
          $error("cluster_members exp %0d got %0d", exp_r.members, got.members); errors++;
        end
        if (got.clusters !== exp_r.clusters) begin
          $error("cluster_total exp %0d got %0d", exp_r.clusters, got.clusters); errors++;
        end
        if (got.ovf !== exp_r.ovf) begin
          $error("overflow exp %0d got %0d", exp_r.ovf, got.ovf); errors++;
        end
      end
    end
    if (cycles > TimeLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_set(int n, int spread, int base);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      s.value = SampleW'(base + $urandom_range(spread));
      s.last  = (i == n - 1);
      pending_reqs = {pending_reqs, s};
    end
  endtask

  task automatic push_one(int v, bit lst);
    sample_t s;
    s.value = SampleW'(v);
    s.last  = lst;
    pending_reqs = {pending_reqs, s};
  endtask

  // clustered set: a few centres with tight scatter
  task automatic queue_clustered(int n);
    int centres[4];
    sample_t s;
    foreach (centres[k]) centres[k] = $urandom_range(4095);
    for (int i = 0; i < n; i++) begin
      s.value = SampleW'(centres[$urandom_range(3)] + $urandom_range(2 * gap_now));
      s.last  = (i == n - 1);
      pending_reqs = {pending_reqs, s};
    end
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (s_axis_tvalid && !s_axis_tready) @(posedge clk);
    wait (awaited_means.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // write min_gap while idle
  task automatic set_gap(logic [GapW-1:0] g);
    drain();
    @(posedge clk);
    min_gap_we    <= 1'b1;
    min_gap_wdata <= g;
    @(posedge clk);
    min_gap_we <= 1'b0;
    gap_now = g;
  endtask

  task automatic random_phase(int items);
    int budget;
    budget = items;
    while (budget > 0) begin
      int n, pick;
      pick = $urandom_range(99);
      if (pick < 3)       n = $urandom_range(257, 262);  // beyond capacity
      else if (pick < 12) n = 1;
      else                n = $urandom_range(2, 24);
      if ($urandom_range(3) == 0) queue_set(n, 4095, 0);
      else                        queue_clustered(n);
      budget -= n;
    end
  endtask

  initial begin
    logic [GapW-1:0] gaps[4];
    errors = 0; cycles = 0; reqs_sent = 0; results_seen = 0;
    hold_send = 0;
    send_idle_pct = 17; recv_idle_pct = 68;
    set_dropped = 1'b0;
    gap_now = MinGapReset;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset gap, extremes, single value, ties
    push_one(0, 1);
    push_one(4095, 1);
    push_one(0, 0); push_one(4095, 1);
    push_one(100, 0); push_one(110, 0); push_one(109, 1);        // gap just below threshold
    push_one(5, 0); push_one(6, 0); push_one(500, 0); push_one(501, 1); // tie
    push_one(4095, 0); push_one(4095, 0); push_one(4094, 1);
    push_one(12'hAAA, 0); push_one(12'h555, 1);
    // full store plus drops, incl. the marked value
    queue_set(258, 4095, 0);

    // idle until every result has come
    hold_send = 1;
    wait (pending_reqs.size() > 0);
    hold_send = 0;
    drain();

    set_gap(12'd1);
    push_one(7, 0); push_one(7, 0); push_one(8, 1);
    set_gap(12'd4095);
    push_one(0, 0); push_one(4095, 1);
    push_one(3, 0); push_one(4094, 1);

    gaps[0] = 12'd1; gaps[1] = 12'd4095; gaps[2] = 12'd10; gaps[3] = 12'd0;
    for (int ph = 0; ph < 4; ph++) begin
      set_gap(ph == 3 ? 12'($urandom_range(2, 300)) : gaps[ph]);
      if (ph == 1) begin
        send_idle_pct = 68; recv_idle_pct = 17;
      end else if (ph >= 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      random_phase(180);
    end
    drain();
    repeat (SettleCycles / 100) @(posedge clk);

    $display("%0d requests sent, %0d sets checked, gaps 1..4095, overflow sets included",
             reqs_sent, results_seen);
    if (errors == 0 && awaited_means.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
